// File: sv/vca_pkg.sv
// Voice channel allocator: shared package.
// Holds the transaction structs, field widths, operation codes and default sizes.
// No dependencies.
package vca_pkg;

    localparam int CHANNEL_CAPACITY = 32;
    localparam int FRAME_BITS       = 24;
    localparam int GENERATION_BITS  = 32;

    localparam int OP_W     = 2;
    localparam int PRIO_W   = 16;
    localparam int CHAN_W   = 5;
    localparam int GEN_W    = 32;
    localparam int FRAME_W  = 24;
    localparam int CFG_W    = 6;
    localparam int RESET_CHANNELS = 32;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam logic signed [PRIO_W-1:0] UNOWNED_PRIO = -16'sd1;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [PRIO_W-1:0] request_priority;
        logic                     new_owner_valid;
        logic signed [PRIO_W-1:0] new_owner_priority;
        logic [CHAN_W-1:0]        target_channel;
        logic [GEN_W-1:0]         handle_generation;
        logic [FRAME_W-1:0]       play_position;
        logic [FRAME_W-1:0]       sound_frames;
    } t_item;

    typedef struct packed {
        logic              granted;
        logic [CHAN_W-1:0] granted_channel;
        logic [GEN_W-1:0]  granted_generation;
        logic              stolen;
        logic              channel_active;
    } t_result;

endpackage

// File: sv/vca_store.sv
// Voice channel allocator: per-channel entry memory (priority, position, length,
// generation) with registered read and per-entry written bits.
// Depends on vca_pkg.
module vca_store #(
    parameter int CHANNEL_CAPACITY = vca_pkg::CHANNEL_CAPACITY,
    parameter int FRAME_BITS       = vca_pkg::FRAME_BITS,
    parameter int GENERATION_BITS  = vca_pkg::GENERATION_BITS,
    localparam int CHW = (CHANNEL_CAPACITY > 1) ? $clog2(CHANNEL_CAPACITY) : 1,
    localparam int PW  = vca_pkg::PRIO_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [CHW-1:0]              i_rd_addr,
    output logic signed [PW-1:0]        o_rd_prio,
    output logic [FRAME_BITS-1:0]       o_rd_pos,
    output logic [FRAME_BITS-1:0]       o_rd_len,
    output logic [GENERATION_BITS-1:0]  o_rd_gen,
    input  logic                        i_wr_en,
    input  logic [CHW-1:0]              i_wr_addr,
    input  logic signed [PW-1:0]        i_wr_prio,
    input  logic [FRAME_BITS-1:0]       i_wr_pos,
    input  logic [FRAME_BITS-1:0]       i_wr_len,
    input  logic [GENERATION_BITS-1:0]  i_wr_gen
);

    localparam int EW = PW + 2 * FRAME_BITS + GENERATION_BITS;

    logic [EW-1:0]               r_mem [CHANNEL_CAPACITY];
    logic [CHANNEL_CAPACITY-1:0] r_vld;
    logic [EW-1:0]               r_rd_data;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_prio, i_wr_pos, i_wr_len, i_wr_gen};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // never-written entries read as zero
    assign {o_rd_prio, o_rd_pos, o_rd_len, o_rd_gen} = r_rd_vld ? r_rd_data : '0;

endmodule

// File: sv/vca_rank.sv
// Voice channel allocator: progress ratio of the entry under scan and registered
// cross products against the current steal candidate.
// Depends on vca_pkg for the default frame width.
module vca_rank #(
    parameter int FRAME_BITS = vca_pkg::FRAME_BITS
) (
    input  logic                  i_clk,
    input  logic [FRAME_BITS-1:0] i_ent_pos,
    input  logic [FRAME_BITS-1:0] i_ent_len,
    input  logic [FRAME_BITS-1:0] i_cand_num,
    input  logic [FRAME_BITS-1:0] i_cand_den,
    output logic [FRAME_BITS-1:0] o_ent_num,
    output logic [FRAME_BITS-1:0] o_ent_den,
    output logic                  o_further
);

    localparam int PW = 2 * FRAME_BITS;

    logic [PW-1:0] r_prod_ent;
    logic [PW-1:0] r_prod_cand;

    // zero length counts as complete: ratio 1/1
    always_comb begin
        if (i_ent_len == '0) begin
            o_ent_num = FRAME_BITS'(1);
            o_ent_den = FRAME_BITS'(1);
        end else begin
            o_ent_num = i_ent_pos;
            o_ent_den = i_ent_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_ent  <= PW'(o_ent_num) * PW'(i_cand_den);
        r_prod_cand <= PW'(i_cand_num) * PW'(o_ent_den);
    end

    assign o_further = r_prod_ent > r_prod_cand;

endmodule

// File: sv/voice_channel_allocator_top.sv
// Voice channel allocator: top level with command sequencer, active/owned flags,
// generation counter and result register.
// Depends on vca_pkg, vca_store and vca_rank.
//
//  port group          dir  handshake                   payload
//  start / busy        in   start & !busy accepts       i_item (vca_pkg::t_item)
//  o_done              out  one-cycle strobe, no stall  o_result (vca_pkg::t_result)
//  i_cfg_we            in   write when high             i_cfg_data (channels_in_use)
//
// Allocate scans one channel per read: channel 0 is evaluated directly, each later
// channel goes through memory read, then cross-product compare; then decide, and
// grant unless refused. A free channel ends the scan and is granted at once. Update,
// stop and query pass through a single lookup state after acceptance; an out-of-range
// index answers without going busy. Result shows the cycle after the final state.
// Reset is synchronous, active low. Results cannot be stalled.
module voice_channel_allocator_top #(
    parameter int CHANNEL_CAPACITY = vca_pkg::CHANNEL_CAPACITY,
    parameter int FRAME_BITS       = vca_pkg::FRAME_BITS,
    parameter int GENERATION_BITS  = vca_pkg::GENERATION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  vca_pkg::t_item                i_item,
    output logic                          o_done,
    output vca_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [vca_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CHW  = (CHANNEL_CAPACITY > 1) ? $clog2(CHANNEL_CAPACITY) : 1;
    localparam int NW   = $clog2(CHANNEL_CAPACITY + 1);
    localparam int KW   = (NW > vca_pkg::CFG_W) ? NW : vca_pkg::CFG_W;
    localparam int PW   = vca_pkg::PRIO_W;
    localparam int GW   = vca_pkg::GEN_W;
    localparam int CIW  = vca_pkg::CHAN_W;
    localparam int GMX  = (GENERATION_BITS > GW) ? GENERATION_BITS : GW;
    localparam int RSTN = (vca_pkg::RESET_CHANNELS > CHANNEL_CAPACITY) ?
                          CHANNEL_CAPACITY : vca_pkg::RESET_CHANNELS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOK   = 6'b000010,
        S_EVAL   = 6'b000100,
        S_CMP    = 6'b001000,
        S_DECIDE = 6'b010000,
        S_GRANT  = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    vca_pkg::t_item               r_cmd, n_cmd;
    logic [NW-1:0]                r_count, n_count;
    logic [CHANNEL_CAPACITY-1:0]  r_active, n_active;
    logic [CHANNEL_CAPACITY-1:0]  r_owned, n_owned;
    logic [CHW-1:0]               r_idx, n_idx;
    logic [CHW-1:0]               r_cand_idx, n_cand_idx;
    logic signed [PW-1:0]         r_cand_prio, n_cand_prio;
    logic [FRAME_BITS-1:0]        r_cand_num, n_cand_num;
    logic [FRAME_BITS-1:0]        r_cand_den, n_cand_den;
    logic [CHW-1:0]               r_gch, n_gch;
    logic                         r_steal, n_steal;
    logic [GENERATION_BITS-1:0]   r_next_gen, n_next_gen;
    logic                         r_done, n_done;
    vca_pkg::t_result             r_res, n_res;

    logic signed [PW-1:0]         rd_prio;
    logic [FRAME_BITS-1:0]        rd_pos;
    logic [FRAME_BITS-1:0]        rd_len;
    logic [GENERATION_BITS-1:0]   rd_gen;
    logic [FRAME_BITS-1:0]        ent_num;
    logic [FRAME_BITS-1:0]        ent_den;
    logic                         further;

    logic                         wr_en;
    logic [CHW-1:0]               wr_addr;
    logic signed [PW-1:0]         wr_prio;
    logic [FRAME_BITS-1:0]        wr_pos;
    logic [FRAME_BITS-1:0]        wr_len;
    logic [GENERATION_BITS-1:0]   wr_gen;

    logic signed [PW-1:0]         ent_prio;
    logic                         last_ch;
    logic                         idx_ok;
    logic                         gen_match;
    logic [GENERATION_BITS-1:0]   gen_take;
    logic [KW-1:0]                cfg_ext;
    logic [NW-1:0]                cfg_count;

    vca_store #(
        .CHANNEL_CAPACITY(CHANNEL_CAPACITY),
        .FRAME_BITS      (FRAME_BITS),
        .GENERATION_BITS (GENERATION_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_addr(n_idx),
        .o_rd_prio(rd_prio),
        .o_rd_pos (rd_pos),
        .o_rd_len (rd_len),
        .o_rd_gen (rd_gen),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_prio(wr_prio),
        .i_wr_pos (wr_pos),
        .i_wr_len (wr_len),
        .i_wr_gen (wr_gen)
    );

    vca_rank #(
        .FRAME_BITS(FRAME_BITS)
    ) u_rank (
        .i_clk     (i_clk),
        .i_ent_pos (rd_pos),
        .i_ent_len (rd_len),
        .i_cand_num(r_cand_num),
        .i_cand_den(r_cand_den),
        .o_ent_num (ent_num),
        .o_ent_den (ent_den),
        .o_further (further)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    assign ent_prio  = r_owned[r_idx] ? rd_prio : vca_pkg::UNOWNED_PRIO;
    assign last_ch   = (KW'(r_idx) + 1'b1) >= KW'(r_count);
    assign idx_ok    = KW'(i_item.target_channel) < KW'(r_count);
    assign gen_match = (r_cmd.handle_generation != '0) &&
                       (GMX'(rd_gen) == GMX'(r_cmd.handle_generation));
    assign gen_take  = (r_next_gen == '0) ? GENERATION_BITS'(1) : r_next_gen;

    assign wr_en   = ((r_state == S_LOOK) && (r_cmd.operation == vca_pkg::OP_UPDATE)) ||
                     (r_state == S_GRANT);
    assign wr_addr = (r_state == S_GRANT) ? r_gch : r_idx;
    assign wr_prio = (r_state == S_GRANT) ? r_cmd.new_owner_priority : rd_prio;
    assign wr_pos  = (r_state == S_GRANT) ? '0 : FRAME_BITS'(r_cmd.play_position);
    assign wr_len  = (r_state == S_GRANT) ? '0 : FRAME_BITS'(r_cmd.sound_frames);
    assign wr_gen  = (r_state == S_GRANT) ? gen_take : rd_gen;

    // channel count clamp to 1..capacity
    assign cfg_ext = KW'(i_cfg_data);
    always_comb begin
        if (cfg_ext == '0) begin
            cfg_count = NW'(1);
        end else if (cfg_ext > KW'(CHANNEL_CAPACITY)) begin
            cfg_count = NW'(CHANNEL_CAPACITY);
        end else begin
            cfg_count = NW'(cfg_ext);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_active    = r_active;
        n_owned     = r_owned;
        n_idx       = r_idx;
        n_cand_idx  = r_cand_idx;
        n_cand_prio = r_cand_prio;
        n_cand_num  = r_cand_num;
        n_cand_den  = r_cand_den;
        n_gch       = r_gch;
        n_steal     = r_steal;
        n_next_gen  = r_next_gen;
        n_done      = 1'b0;
        n_res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_item;
                    if (i_item.operation == vca_pkg::OP_ALLOC) begin
                        n_idx   = '0;
                        n_state = S_EVAL;
                    end else if (idx_ok) begin
                        n_idx   = CHW'(i_item.target_channel);
                        n_state = S_LOOK;
                    end else begin
                        n_done = 1'b1;
                        n_res  = '0;
                    end
                end
            end
            S_LOOK: begin
                n_done  = 1'b1;
                n_res   = '0;
                n_state = S_IDLE;
                unique case (r_cmd.operation)
                    vca_pkg::OP_STOP: begin
                        if (gen_match) begin
                            n_active[r_idx] = 1'b0;
                        end
                    end
                    vca_pkg::OP_QUERY: begin
                        n_res.channel_active = gen_match && r_active[r_idx];
                    end
                    default: begin
                    end
                endcase
            end
            S_EVAL: begin
                if (!r_active[r_idx]) begin
                    n_gch   = r_idx;
                    n_steal = 1'b0;
                    n_state = S_GRANT;
                end else if (r_idx == '0) begin
                    n_cand_idx  = r_idx;
                    n_cand_prio = ent_prio;
                    n_cand_num  = ent_num;
                    n_cand_den  = ent_den;
                    if (last_ch) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if ((ent_prio < r_cand_prio) || ((ent_prio == r_cand_prio) && further)) begin
                    n_cand_idx  = r_idx;
                    n_cand_prio = ent_prio;
                    n_cand_num  = ent_num;
                    n_cand_den  = ent_den;
                end
                if (last_ch) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_DECIDE: begin
                if (r_cmd.request_priority < r_cand_prio) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_gch   = r_cand_idx;
                    n_steal = 1'b1;
                    n_state = S_GRANT;
                end
            end
            S_GRANT: begin
                n_active[r_gch] = 1'b1;
                n_owned[r_gch]  = r_cmd.new_owner_valid;
                n_next_gen      = gen_take + 1'b1;
                n_done          = 1'b1;
                n_res.granted            = 1'b1;
                n_res.granted_channel    = CIW'(r_gch);
                n_res.granted_generation = GW'(gen_take);
                n_res.stolen             = r_steal;
                n_res.channel_active     = 1'b0;
                n_state                  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // shrink deactivates channels from the new count up to the old one
        if (i_cfg_we) begin
            n_count = cfg_count;
            for (int i = 0; i < CHANNEL_CAPACITY; i++) begin
                if ((KW'(i) >= KW'(cfg_count)) && (KW'(i) < KW'(r_count))) begin
                    n_active[i] = 1'b0;
                    n_owned[i]  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= NW'(RSTN);
            r_active   <= '0;
            r_owned    <= '0;
            r_idx      <= '0;
            r_next_gen <= GENERATION_BITS'(1);
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_active   <= n_active;
            r_owned    <= n_owned;
            r_idx      <= n_idx;
            r_next_gen <= n_next_gen;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cand_idx  <= n_cand_idx;
        r_cand_prio <= n_cand_prio;
        r_cand_num  <= n_cand_num;
        r_cand_den  <= n_cand_den;
        r_gch       <= n_gch;
        r_steal     <= n_steal;
        r_res       <= n_res;
    end

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction neither busy nor answered");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (KW'(r_idx) < KW'(r_count)))
        else $error("scan index beyond channel count");

    a_stolen_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.stolen || o_result.granted)) |-> !o_result.channel_active)
        else $error("grant result carries query flag");

endmodule

// File: sim/voice_channel_allocator_top_test.sv
// Self-checking testbench for voice_channel_allocator_top: a directed table, then random
// phases over several channel counts. Results are scored against an in-bench voice table
// model or typed results. Depends on vca_pkg and the voice_channel_allocator_top RTL.
module voice_channel_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vca_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 80;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int MAX_REPORTS     = 10;

    localparam t_result EMPTY_RESULT = '0;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_value;
        t_item            cmd;
        bit               typed;
        t_result          result;
    } t_stim_row;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    t_item            i_item     = '0;
    logic             busy;
    logic             o_done;
    t_result          o_result;

    voice_channel_allocator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // voice table model
    bit                       ch_active     [CHANNEL_CAPACITY];
    bit                       ch_owned      [CHANNEL_CAPACITY];
    logic signed [PRIO_W-1:0] ch_owner_prio [CHANNEL_CAPACITY];
    logic [FRAME_W-1:0]       ch_position   [CHANNEL_CAPACITY];
    logic [FRAME_W-1:0]       ch_length     [CHANNEL_CAPACITY];
    logic [GEN_W-1:0]         ch_generation [CHANNEL_CAPACITY];
    logic [GEN_W-1:0]         gen_counter;
    int                       channel_count;

    t_result   pending_results [$];
    t_stim_row directed_rows [$];
    int        error_count = 0;
    int        burst_left  = 0;

    logic [CFG_W-1:0] phase_counts [RANDOM_PHASES] =
        '{6'd4, 6'd32, 6'd1, 6'd63, 6'd2, 6'd0, 6'd9, 6'd20};

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void reset_voice_table();
        for (int i = 0; i < CHANNEL_CAPACITY; i++) begin
            ch_active[i]     = 1'b0;
            ch_owned[i]      = 1'b0;
            ch_owner_prio[i] = '0;
            ch_position[i]   = '0;
            ch_length[i]     = '0;
            ch_generation[i] = '0;
        end
        gen_counter   = 1;
        channel_count = RESET_CHANNELS;
    endfunction

    function automatic void apply_channel_count(logic [CFG_W-1:0] value);
        int n;
        n = (value == 0) ? 1 : (int'(value) > CHANNEL_CAPACITY ? CHANNEL_CAPACITY : int'(value));
        for (int i = n; i < channel_count; i++) begin
            ch_active[i] = 1'b0;
            ch_owned[i]  = 1'b0;
        end
        channel_count = n;
    endfunction

    function automatic int voice_prio(int ch);
        return ch_owned[ch] ? int'(ch_owner_prio[ch]) : int'(UNOWNED_PRIO);
    endfunction

    // exact ratio compare by cross multiplication; empty length counts as complete
    function automatic bit further_along(int a, int b);
        logic [47:0] num_a, den_a, num_b, den_b;
        num_a = (ch_length[a] == 0) ? 48'd1 : 48'(ch_position[a]);
        den_a = (ch_length[a] == 0) ? 48'd1 : 48'(ch_length[a]);
        num_b = (ch_length[b] == 0) ? 48'd1 : 48'(ch_position[b]);
        den_b = (ch_length[b] == 0) ? 48'd1 : 48'(ch_length[b]);
        return (num_a * den_b) > (num_b * den_a);
    endfunction

    function automatic logic [GEN_W-1:0] take_generation();
        logic [GEN_W-1:0] g;
        g = gen_counter;
        gen_counter = g + 1'b1;
        if (g == '0) begin
            g = gen_counter;
            gen_counter = g + 1'b1;
        end
        return g;
    endfunction

    function automatic t_result predict_voice(t_item cmd);
        t_result res;
        int      ch;
        int      idx;
        bit      found;
        bit      match;
        res   = '0;
        ch    = 0;
        found = 1'b0;
        idx   = int'(cmd.target_channel);
        if (cmd.operation == OP_ALLOC) begin
            for (int i = 0; i < channel_count; i++) begin
                if (!found && !ch_active[i]) begin
                    ch    = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                for (int i = 1; i < channel_count; i++) begin
                    if (voice_prio(i) < voice_prio(ch) ||
                        (voice_prio(i) == voice_prio(ch) && further_along(i, ch)))
                        ch = i;
                end
                if (int'($signed(cmd.request_priority)) < voice_prio(ch))
                    return res;
                res.stolen = 1'b1;
            end
            ch_active[ch] = 1'b1;
            ch_owned[ch]  = cmd.new_owner_valid;
            if (cmd.new_owner_valid)
                ch_owner_prio[ch] = cmd.new_owner_priority;
            ch_position[ch]        = '0;
            ch_length[ch]          = '0;
            ch_generation[ch]      = take_generation();
            res.granted            = 1'b1;
            res.granted_channel    = CHAN_W'(ch);
            res.granted_generation = ch_generation[ch];
        end else if (idx < channel_count) begin
            match = (cmd.handle_generation != '0) && (ch_generation[idx] == cmd.handle_generation);
            case (cmd.operation)
                OP_UPDATE: begin
                    ch_position[idx] = cmd.play_position;
                    ch_length[idx]   = cmd.sound_frames;
                end
                OP_STOP: begin
                    if (match)
                        ch_active[idx] = 1'b0;
                end
                default: begin
                    res.channel_active = match && ch_active[idx];
                end
            endcase
        end
        return res;
    endfunction

    function automatic t_item alloc_cmd(int req, bit own, int own_prio);
        t_item c;
        c = '0;
        c.operation          = OP_ALLOC;
        c.request_priority   = PRIO_W'(req);
        c.new_owner_valid    = own;
        c.new_owner_priority = PRIO_W'(own_prio);
        return c;
    endfunction

    function automatic t_item chan_cmd(logic [OP_W-1:0] op, int idx, logic [GEN_W-1:0] hgen,
                                       logic [FRAME_W-1:0] pos, logic [FRAME_W-1:0] len);
        t_item c;
        c = '0;
        c.operation         = op;
        c.target_channel    = CHAN_W'(idx);
        c.handle_generation = hgen;
        c.play_position     = pos;
        c.sound_frames      = len;
        return c;
    endfunction

    function automatic t_result grant_res(int ch, int gen, bit stolen);
        t_result r;
        r = '0;
        r.granted            = 1'b1;
        r.granted_channel    = CHAN_W'(ch);
        r.granted_generation = GEN_W'(gen);
        r.stolen             = stolen;
        return r;
    endfunction

    function automatic void add_cmd(t_item c, bit typed, t_result r);
        t_stim_row row;
        row.is_cfg    = 1'b0;
        row.cfg_value = '0;
        row.cmd       = c;
        row.typed     = typed;
        row.result    = r;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_cfg(logic [CFG_W-1:0] value);
        t_stim_row row;
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        row.cmd       = '0;
        row.typed     = 1'b0;
        row.result    = '0;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void build_directed_rows();
        t_result active_hit;
        active_hit = '0;
        active_hit.channel_active = 1'b1;
        add_cmd(alloc_cmd(0, 1'b1, 32767), 1'b1, grant_res(0, 1, 1'b0));
        add_cmd(alloc_cmd(-32768, 1'b0, -32768), 1'b1, grant_res(1, 2, 1'b0));
        add_cmd(chan_cmd(OP_QUERY, 0, 1, '0, '0), 1'b1, active_hit);
        add_cmd(chan_cmd(OP_QUERY, 0, 0, '0, '0), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_QUERY, 0, 2, '0, '0), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_STOP, 1, 0, '0, '0), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_STOP, 1, 2, '0, '0), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_QUERY, 1, 2, '0, '0), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_UPDATE, 0, '1, '1, '1), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_UPDATE, 31, '0, '1, '0), 1'b1, EMPTY_RESULT);
        add_cmd(alloc_cmd(5, 1'b1, 100), 1'b1, grant_res(1, 3, 1'b0));
        add_cfg(6'd2);
        // all channels busy, request below the weakest owner
        add_cmd(alloc_cmd(-32768, 1'b1, 0), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_UPDATE, 1, 0, 24'd5, 24'd10), 1'b0, EMPTY_RESULT);
        add_cmd(alloc_cmd(100, 1'b0, 0), 1'b1, grant_res(1, 4, 1'b1));
        add_cmd(chan_cmd(OP_UPDATE, 0, 0, 24'd0, 24'd0), 1'b0, EMPTY_RESULT);
        add_cmd(alloc_cmd(-2, 1'b1, 0), 1'b1, EMPTY_RESULT);
        add_cmd(alloc_cmd(-1, 1'b1, -32768), 1'b1, grant_res(1, 5, 1'b1));
        add_cfg(6'd0);
        add_cmd(chan_cmd(OP_UPDATE, 1, 5, 24'd3, 24'd4), 1'b1, EMPTY_RESULT);
        add_cmd(chan_cmd(OP_QUERY, 1, 5, '0, '0), 1'b1, EMPTY_RESULT);
        add_cmd(alloc_cmd(32767, 1'b0, 0), 1'b1, grant_res(0, 6, 1'b1));
        add_cfg(6'd63);
        add_cmd(chan_cmd(OP_QUERY, 0, 6, '0, '0), 1'b1, active_hit);
        add_cmd(alloc_cmd(0, 1'b1, 7), 1'b1, grant_res(1, 7, 1'b0));
    endfunction

    // small priorities most of the time so ties happen
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        if ($urandom_range(0, 3) == 0)
            return PRIO_W'($urandom);
        return PRIO_W'(int'($urandom_range(0, 8)) - 4);
    endfunction

    function automatic t_item random_cmd();
        t_item c;
        int    sel;
        int    idx;
        sel = $urandom_range(0, 99);
        c.operation = (sel < 35) ? OP_ALLOC : (sel < 60) ? OP_UPDATE :
                      (sel < 75) ? OP_STOP : OP_QUERY;
        c.request_priority   = pick_priority();
        c.new_owner_valid    = 1'($urandom_range(0, 1));
        c.new_owner_priority = pick_priority();
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CHANNEL_CAPACITY - 1)
                                          : $urandom_range(0, channel_count - 1);
        c.target_channel = CHAN_W'(idx);
        case ($urandom_range(0, 9))
            0:       c.handle_generation = '0;
            1:       c.handle_generation = ch_generation[idx] + 1'b1;
            2:       c.handle_generation = GEN_W'($urandom);
            default: c.handle_generation = ch_generation[idx];
        endcase
        case ($urandom_range(0, 7))
            0: begin
                c.play_position = FRAME_W'($urandom);
                c.sound_frames  = FRAME_W'($urandom);
            end
            1: begin
                c.play_position = FRAME_W'($urandom_range(0, 12));
                c.sound_frames  = '0;
            end
            2: begin
                c.sound_frames  = FRAME_W'($urandom_range(1, 8));
                c.play_position = c.sound_frames + FRAME_W'($urandom_range(1, 8));
            end
            default: begin
                c.play_position = FRAME_W'($urandom_range(0, 12));
                c.sound_frames  = FRAME_W'($urandom_range(0, 12));
            end
        endcase
        return c;
    endfunction

    task automatic issue_command(input t_item cmd, input bit typed, input t_result typed_res);
        int      gap;
        t_result predicted;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 29) == 0)
                burst_left = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1))
                do @(posedge i_clk); while (busy);
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        predicted = predict_voice(cmd);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    task automatic set_channel_count(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_channel_count(value);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with no transaction outstanding", $time);
            end else begin
                want = pending_results.pop_front();
                if (o_result.granted !== want.granted ||
                    o_result.granted_channel !== want.granted_channel ||
                    o_result.granted_generation !== want.granted_generation ||
                    o_result.stolen !== want.stolen ||
                    o_result.channel_active !== want.channel_active) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp g=%0d ch=%0d gen=%0h st=%0d act=%0d",
                                 $time, want.granted, want.granted_channel,
                                 want.granted_generation, want.stolen, want.channel_active);
                        $display("    got g=%0d ch=%0d gen=%0h st=%0d act=%0d",
                                 o_result.granted, o_result.granted_channel,
                                 o_result.granted_generation, o_result.stolen,
                                 o_result.channel_active);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] count_value;
        reset_voice_table();
        build_directed_rows();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg)
                set_channel_count(directed_rows[r].cfg_value);
            else
                issue_command(directed_rows[r].cmd, directed_rows[r].typed,
                              directed_rows[r].result);
        end
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            count_value = (p == 6) ? CFG_W'($urandom) : phase_counts[p];
            set_channel_count(count_value);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                issue_command(random_cmd(), 1'b0, EMPTY_RESULT);
        end
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
